>>> sv/bounding_circle_merge_macros.svh
// assertion macros for the bounding circle merge block
`ifndef BOUNDING_CIRCLE_MERGE_MACROS_SVH
`define BOUNDING_CIRCLE_MERGE_MACROS_SVH
`ifndef ASSERT_OFF
`define BCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define BCM_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BCM_ASSERT(label, clk, rst_n, prop)
`define BCM_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> sv/bcm_pkg.sv
package bcm_pkg;
    localparam int CoordW = 32;
    localparam int RadW = 31;
    localparam int ThrW = 32;
    localparam logic OP_SET = 1'b0;
    localparam logic OP_MERGE = 1'b1;
    localparam int SqrtSteps = 33;
    localparam int DivSteps = 64;
endpackage

>>> sv/bounding_circle_merge.sv
// bounding circle merge: keeps a running 2d circle in q16.16
// input channel s_axis: tdata carries in_center_x, in_center_y, in_radius,
// tuser carries opcode (0 set, 1 merge); one result per input on m_axis
// output channel m_axis: tdata carries out_center_x, out_center_y, out_radius
// cfg channel writes coincident_threshold_sq while the block is idle
// a set item loads the circle and goes to the output, a merge with coincident
// centers stops after the compare; otherwise a merge squares the deltas and
// compares, then runs 33 steps of the digit-by-digit square root, then for a
// spanning result (not when one circle holds the other) two 64-step restoring
// divisions (one per axis) on the shared divider with a multiply and add
// after each; the next item can be taken as soon as the result is in the
// output register
// one item is worked on at a time; s_axis_tready is low while it is worked on
// reset clears the circle to zero and the threshold to one
// when the receiver stalls the result holds in the output register; the next
// item may still be taken and its result waits until the register is free
`include "bounding_circle_merge_macros.svh"
module bounding_circle_merge #(
    parameter int CoordW = bcm_pkg::CoordW,
    parameter int RadW = bcm_pkg::RadW
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // in_center_x, in_center_y, in_radius, pad
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // out_center_x, out_center_y, out_radius, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ = 4'd1;
    localparam logic [3:0] ST_CMP = 4'd2;
    localparam logic [3:0] ST_SQRT = 4'd3;
    localparam logic [3:0] ST_DECIDE = 4'd4;
    localparam logic [3:0] ST_DIVX = 4'd5;
    localparam logic [3:0] ST_MULX = 4'd6;
    localparam logic [3:0] ST_DIVY = 4'd7;
    localparam logic [3:0] ST_MULY = 4'd8;
    localparam logic [3:0] ST_OUT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [31:0] thr_reg;
    logic signed [CoordW-1:0] cx_reg, cy_reg, x2_reg, y2_reg;
    logic [RadW-1:0] r_reg, r2_reg;
    logic op_reg;
    logic signed [CoordW:0] dx_reg, dy_reg;
    logic [65:0] sx_reg, sy_reg;
    logic [32:0] d_reg;
    logic [63:0] off_reg;
    logic [95:0] out_reg;
    logic out_valid_reg;

    logic sq_start, div_start, sq_done, div_done;
    logic [32:0] sq_root;
    logic [63:0] div_quo, div_num;
    logic [32:0] mag_dx, mag_dy, mag_sel;
    logic [31:0] absdiff;
    logic signed [32:0] rdiff;
    logic [50:0] lensq;
    logic [33:0] nr;
    logic signed [CoordW:0] delta_sel;
    logic signed [CoordW-1:0] c_sel;
    logic signed [35:0] mid, res;
    logic signed [CoordW-1:0] res_sat;
    logic neg;

    bcm_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start),
        .rad(sx_reg + sy_reg), .done(sq_done), .root(sq_root));
    bcm_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den({1'b0, d_reg}), .done(div_done), .quo(div_quo));

    assign mag_dx = dx_reg[CoordW] ? 33'(-dx_reg) : 33'(dx_reg);
    assign mag_dy = dy_reg[CoordW] ? 33'(-dy_reg) : 33'(dy_reg);
    assign lensq = {1'b0, sx_reg[65:16]} + {1'b0, sy_reg[65:16]};
    assign rdiff = $signed({2'b0, r2_reg}) - $signed({2'b0, r_reg});
    assign absdiff = rdiff[32] ? 32'(-rdiff) : 32'(rdiff);
    assign nr = ({1'b0, d_reg} + 34'(r_reg) + 34'(r2_reg)) >> 1;
    assign mag_sel = (state_reg == ST_DECIDE) ? mag_dx : mag_dy;
    assign div_num = {1'b0, mag_sel, 30'b0};
    assign delta_sel = (state_reg == ST_MULX) ? dx_reg : dy_reg;
    assign c_sel = (state_reg == ST_MULX) ? cx_reg : cy_reg;
    assign neg = delta_sel[CoordW] != rdiff[32];
    assign mid = 36'(c_sel) + 36'(delta_sel >>> 1);
    assign res = neg ? mid - $signed({1'b0, off_reg[34:0]})
                     : mid + $signed({1'b0, off_reg[34:0]});
    assign res_sat = (res > 36'sd2147483647) ? 32'sh7fffffff :
                     (res < -36'sd2147483648) ? 32'sh80000000 : res[31:0];

    assign sq_start = (state_reg == ST_CMP) && (lensq >= {19'b0, thr_reg});
    assign div_start = ((state_reg == ST_DECIDE) && (d_reg > {1'b0, absdiff}))
                       || (state_reg == ST_MULX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_axis_tvalid && s_axis_tready)
                           state_next = ST_SQ;
            ST_SQ:     state_next = (op_reg == bcm_pkg::OP_SET) ? ST_OUT : ST_CMP;
            ST_CMP:    state_next = sq_start ? ST_SQRT : ST_OUT;
            ST_SQRT:   if (sq_done)
                           state_next = ST_DECIDE;
            ST_DECIDE: state_next = div_start ? ST_DIVX : ST_OUT;
            ST_DIVX:   if (div_done)
                           state_next = ST_MULX;
            ST_MULX:   state_next = ST_DIVY;
            ST_DIVY:   if (div_done)
                           state_next = ST_MULY;
            ST_MULY:   state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg)
                           state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= 32'd1;
            cx_reg <= '0;
            cy_reg <= '0;
            r_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_SQ:
                    if (op_reg == bcm_pkg::OP_SET)
                    begin
                        cx_reg <= x2_reg;
                        cy_reg <= y2_reg;
                        r_reg <= r2_reg;
                    end
                ST_CMP:
                    if (!sq_start && r2_reg > r_reg)
                        r_reg <= r2_reg;
                ST_DECIDE:
                    if (!div_start && r2_reg > r_reg)
                    begin
                        cx_reg <= x2_reg;
                        cy_reg <= y2_reg;
                        r_reg <= r2_reg;
                    end
                ST_MULX:
                    cx_reg <= res_sat;
                ST_MULY:
                begin
                    cy_reg <= res_sat;
                    r_reg <= (nr > 34'h7fffffff) ? 31'h7fffffff : nr[30:0];
                end
                ST_OUT:
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg <= s_axis_tuser;
            x2_reg <= s_axis_tdata[31:0];
            y2_reg <= s_axis_tdata[63:32];
            r2_reg <= s_axis_tdata[94:64];
        end
        if (state_reg == ST_SQ)
        begin
            sx_reg <= 66'(mag_dx * mag_dx);
            sy_reg <= 66'(mag_dy * mag_dy);
        end
        if (sq_done)
            d_reg <= sq_root;
        if (div_done)
            off_reg <= 64'((div_quo[32:0] * 33'(absdiff)) >> 31);
        if (state_reg == ST_OUT && !out_valid_reg)
            out_reg <= {1'b0, r_reg, cy_reg, cx_reg};
    end

    // deltas of the incoming centers from the current circle center
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            dx_reg <= 33'($signed(s_axis_tdata[31:0])) - 33'(cx_reg);
            dy_reg <= 33'($signed(s_axis_tdata[63:32])) - 33'(cy_reg);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    `BCM_ASSERT(a_busy_no_accept, clk, rst_n, (state_reg != ST_IDLE) |-> !s_axis_tready)
    `BCM_ASSERT(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    `BCM_ASSERT(a_one_unit, clk, rst_n, !(sq_start && div_start))
    `BCM_ASSERT(a_rad_range, clk, rst_n, m_axis_tvalid |-> !m_axis_tdata[95])
endmodule

>>> sv/bcm_divider.sv
module bcm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [33:0] den,
    output logic        done,
    output logic [63:0] quo
);
    logic [63:0] quo_reg, quo_next;
    logic [34:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [34:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[33:0], quo_reg[63]};
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            cnt_next = 7'(bcm_pkg::DivSteps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = trial - {1'b0, den};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // high once the last quotient bit is in quo_reg
    assign done = done_reg;
    assign quo = quo_reg;
endmodule

>>> sv/bcm_sqrt.sv
module bcm_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [65:0] rad,
    output logic        done,
    output logic [32:0] root
);
    logic [65:0] val_reg, val_next;
    logic [35:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [35:0] shifted, trial;

    always_comb
    begin
        val_next = val_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted = {rem_reg[33:0], val_reg[65:64]};
        trial = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            val_next = rad;
            rem_next = '0;
            root_next = '0;
            cnt_next = 6'(bcm_pkg::SqrtSteps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[63:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                root_next = {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                root_next = {root_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    // high once the last root bit is in root_reg
    assign done = done_reg;
    assign root = root_reg;
endmodule
